FILE: rtl/lsap_pkg.sv
// Shared types and constants for the line sensor array position estimator.
`default_nettype none

package lsap_pkg;

    // Fixed field and accumulator widths.
    localparam int unsigned REQ_W     = 2;
    localparam int unsigned IDX_IN_W  = 4;
    localparam int unsigned SMP_IN_W  = 12;
    localparam int unsigned THR_W     = 10;
    localparam int unsigned INV_W     = 10;
    localparam int unsigned POS_W     = 14;
    localparam int unsigned WGT_W     = 14;
    localparam int unsigned TOTAL_W   = 27;
    localparam int unsigned SUM_W     = 14;
    localparam int unsigned CFG_IDX_W = 1;

    // Full scale of one normalized reading and the weight of one sensor step.
    localparam int unsigned SCALE = 1000;

    // Threshold values after reset.
    localparam logic [THR_W-1:0] LINE_THR_RST  = 10'd200;
    localparam logic [THR_W-1:0] NOISE_THR_RST = 10'd50;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CAL   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_MEAS  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_THR  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_THR = 1'd1;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_NSTART,
        S_NWAIT,
        S_INV,
        S_ACC,
        S_FEND,
        S_FWAIT,
        S_OUT
    } lsap_state_t;

endpackage

`default_nettype wire

FILE: rtl/lsap_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module lsap_div #(
    parameter int unsigned DVD_W = 27,
    parameter int unsigned DVS_W = 14
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic      [DVD_W-1:0] quotient
);

    localparam int unsigned CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVD_W-1:0] quo_next;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   shifted;
    logic [DVS_W:0]   trial;
    logic             ge;

    // One restoring step: shift in the next dividend bit and try the subtract.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DVD_W-1]};
        trial    = shifted - {1'b0, dvs_reg};
        ge       = (shifted >= {1'b0, dvs_reg});
        rem_next = ge ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
        quo_next = {quo_reg[DVD_W-2:0], ge};
    end

    // Iteration counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(DVD_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= (cnt_reg == CNT_W'(1));
            end
        end
    end

    // Operand and partial remainder registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> cnt_reg == '0)
        else $error("divider started while busy");
    a_start_load: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> cnt_reg == CNT_W'(DVD_W))
        else $error("divider count not loaded");
    a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> cnt_reg == '0 && $past(cnt_reg) == CNT_W'(1))
        else $error("divider done out of sequence");
`endif

endmodule

`default_nettype wire

FILE: rtl/lsap_cal.sv
// Per-sensor calibration range store with clear and widen operations.
`default_nettype none

module lsap_cal #(
    parameter int unsigned NUM_SENSORS = 12,
    parameter int unsigned SAMPLE_BITS = 12,
    parameter int unsigned IDX_W       = 4
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   clr,
    input  wire logic                   upd,
    input  wire logic [IDX_W-1:0]       wr_idx,
    input  wire logic [SAMPLE_BITS-1:0] wr_sample,
    input  wire logic [IDX_W-1:0]       rd_idx,
    output logic      [SAMPLE_BITS-1:0] rd_min,
    output logic      [SAMPLE_BITS-1:0] rd_max
);

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

    logic [SAMPLE_BITS-1:0] min_reg [NUM_SENSORS];
    logic [SAMPLE_BITS-1:0] max_reg [NUM_SENSORS];

    // Clear sets an empty range; a sample widens the range of its sensor.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SENSORS; i++)
            begin
                min_reg[i] <= '0;
                max_reg[i] <= SAMPLE_MAX;
            end
        end
        else if (clr)
        begin
            for (int i = 0; i < NUM_SENSORS; i++)
            begin
                min_reg[i] <= SAMPLE_MAX;
                max_reg[i] <= '0;
            end
        end
        else if (upd)
        begin
            if (wr_sample < min_reg[wr_idx])
            begin
                min_reg[wr_idx] <= wr_sample;
            end
            if (wr_sample > max_reg[wr_idx])
            begin
                max_reg[wr_idx] <= wr_sample;
            end
        end
    end

    // Range of the sensor under measurement.
    assign rd_min = min_reg[rd_idx];
    assign rd_max = max_reg[rd_idx];

`ifndef ASSERT_OFF
    a_no_clr_upd: assert property (@(posedge clk) disable iff (!rst_n)
        !(clr && upd))
        else $error("clear and update together");
    a_clr_empty: assert property (@(posedge clk) disable iff (!rst_n)
        clr |=> min_reg[0] == SAMPLE_MAX && max_reg[0] == '0)
        else $error("clear did not empty the range");
    a_upd_order: assert property (@(posedge clk) disable iff (!rst_n)
        upd && !clr && wr_idx == '0 |=> min_reg[0] <= max_reg[0])
        else $error("range inverted after a calibration sample");
`endif

endmodule

`default_nettype wire

FILE: rtl/line_sensor_array_position.sv
// Line sensor array position estimator: sequencer, accumulators and output register.
//
// Usage: items enter on in_valid/in_ready; each carries a request type, a sensor
// index, a raw sample and a frame-last flag. A clear or calibration item is taken
// while idle and in_ready stays high. A measurement item for a sensor in range holds
// the block through operand setup, a wait on the shared divider for the
// normalization, then inversion and accumulation. A reading at or below the
// sensor's minimum, at or above its maximum, or against an empty range skips the
// divide. A measurement item for a sensor out of range is taken without leaving
// idle unless it closes a frame. The item that closes a frame adds a decision
// state and, when the line was seen with a nonzero weight, a second divide for the
// position, then presents one result on out_valid/out_ready. in_ready is low from
// acceptance of a measurement item that starts work until that work is done and
// any result has been taken, so a stalled receiver holds the block with the result
// steady in the output register.
// Thresholds are written through cfg_we/cfg_index/cfg_data; the user must write
// them only while the block is idle, which the block itself does not enforce.
// Reset sets thresholds to 200 and 50, every calibration range to the full
// converter scale, and clears the frame accumulators and the last position.
`default_nettype none

module line_sensor_array_position
    import lsap_pkg::*;
#(
    parameter int unsigned NUM_SENSORS = 12,
    parameter int unsigned SAMPLE_BITS = 12
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [REQ_W-1:0]     req_type,
    input  wire logic [IDX_IN_W-1:0]  sensor_index,
    input  wire logic [SMP_IN_W-1:0]  sample,
    input  wire logic                 frame_last,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic      [POS_W-1:0]     position,
    output logic                      line_seen,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [THR_W-1:0]     cfg_data
);

    localparam int unsigned IDX_W = $clog2(NUM_SENSORS);
    localparam int unsigned NUM_W = SAMPLE_BITS + INV_W;
    localparam int unsigned DVD_W = TOTAL_W;
    localparam int unsigned DVS_W = (SAMPLE_BITS > SUM_W) ? SAMPLE_BITS : SUM_W;
    localparam int unsigned PROD_W = INV_W + WGT_W;
    localparam logic [POS_W-1:0] FULL_POS = POS_W'((NUM_SENSORS - 1) * SCALE);
    localparam logic [POS_W-1:0] HALF_POS = POS_W'(((NUM_SENSORS - 1) * SCALE) / 2);

    lsap_state_t state_reg;
    lsap_state_t state_next;

    logic [THR_W-1:0]       line_thr_reg;
    logic [THR_W-1:0]       noise_thr_reg;
    logic [IDX_IN_W-1:0]    idx_reg;
    logic [SAMPLE_BITS-1:0] smp_reg;
    logic                   last_reg;
    logic                   zero_reg;
    logic                   sat_reg;
    logic [NUM_W-1:0]       num_reg;
    logic [SAMPLE_BITS-1:0] rng_reg;
    logic [WGT_W-1:0]       wgt_reg;
    logic [INV_W-1:0]       inv_reg;
    logic                   seen_reg;
    logic [TOTAL_W-1:0]     total_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [POS_W-1:0]       last_pos_reg;
    logic [POS_W-1:0]       position_reg;
    logic                   line_seen_reg;

    logic                   accept;
    logic                   idx_ok;
    logic [SAMPLE_BITS-1:0] smp_in;
    logic [SAMPLE_BITS-1:0] cal_min;
    logic [SAMPLE_BITS-1:0] cal_max;
    logic                   frame_div;
    logic                   div_start;
    logic                   div_done;
    logic [DVD_W-1:0]       div_dvd;
    logic [DVS_W-1:0]       div_dvs;
    logic [DVD_W-1:0]       div_quo;
    logic [INV_W-1:0]       norm_val;
    logic [PROD_W-1:0]      prod;
    logic [TOTAL_W:0]       total_add;
    logic [SUM_W:0]         sum_add;
    logic [POS_W-1:0]       frame_pos;
    logic [POS_W-1:0]       lost_pos;

    // Input decode.
    assign accept = in_valid && in_ready;
    assign idx_ok = ({1'b0, sensor_index} < (IDX_IN_W + 1)'(NUM_SENSORS));
    assign smp_in = SAMPLE_BITS'(sample);

    // Calibration store.
    lsap_cal #(
        .NUM_SENSORS (NUM_SENSORS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .IDX_W       (IDX_W)
    ) u_cal (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr       (accept && (req_type == REQ_CLEAR)),
        .upd       (accept && (req_type == REQ_CAL) && idx_ok),
        .wr_idx    (sensor_index[IDX_W-1:0]),
        .wr_sample (smp_in),
        .rd_idx    (idx_reg[IDX_W-1:0]),
        .rd_min    (cal_min),
        .rd_max    (cal_max)
    );

    // Shared divider: normalization and frame position.
    assign div_dvd = (state_reg == S_FEND) ? total_reg : DVD_W'(num_reg);
    assign div_dvs = (state_reg == S_FEND) ? DVS_W'(sum_reg) : DVS_W'(rng_reg);

    lsap_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Datapath arithmetic around the divider.
    always_comb
    begin
        if (zero_reg)
        begin
            norm_val = '0;
        end
        else if (sat_reg || (div_quo > DVD_W'(SCALE)))
        begin
            norm_val = INV_W'(SCALE);
        end
        else
        begin
            norm_val = div_quo[INV_W-1:0];
        end
        prod      = PROD_W'(inv_reg) * PROD_W'(wgt_reg);
        total_add = {1'b0, total_reg} + (TOTAL_W + 1)'(prod);
        sum_add   = {1'b0, sum_reg} + (SUM_W + 1)'(inv_reg);
        frame_pos = (div_quo > DVD_W'(FULL_POS)) ? FULL_POS : div_quo[POS_W-1:0];
        lost_pos  = (last_pos_reg < HALF_POS) ? '0 : FULL_POS;
    end

    assign frame_div = seen_reg && (sum_reg != '0);

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (req_type == REQ_MEAS))
                begin
                    if (idx_ok)
                    begin
                        state_next = S_PREP;
                    end
                    else if (frame_last)
                    begin
                        state_next = S_FEND;
                    end
                end
            end
            S_PREP:
            begin
                state_next = S_NSTART;
            end
            S_NSTART:
            begin
                state_next = (zero_reg || sat_reg) ? S_INV : S_NWAIT;
            end
            S_NWAIT:
            begin
                if (div_done)
                begin
                    state_next = S_INV;
                end
            end
            S_INV:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                state_next = last_reg ? S_FEND : S_IDLE;
            end
            S_FEND:
            begin
                state_next = frame_div ? S_FWAIT : S_OUT;
            end
            S_FWAIT:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ready  = (state_reg == S_IDLE);
        out_valid = (state_reg == S_OUT);
        div_start = ((state_reg == S_NSTART) && !zero_reg && !sat_reg) ||
                    ((state_reg == S_FEND) && frame_div);
    end

    // State, thresholds and frame accumulators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            line_thr_reg  <= LINE_THR_RST;
            noise_thr_reg <= NOISE_THR_RST;
            seen_reg      <= 1'b0;
            total_reg     <= '0;
            sum_reg       <= '0;
            last_pos_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LINE_THR:  line_thr_reg  <= cfg_data;
                    CFG_NOISE_THR: noise_thr_reg <= cfg_data;
                    default:       line_thr_reg  <= line_thr_reg;
                endcase
            end
            if (state_reg == S_ACC)
            begin
                if (inv_reg > line_thr_reg)
                begin
                    seen_reg <= 1'b1;
                end
                if (inv_reg > noise_thr_reg)
                begin
                    total_reg <= total_add[TOTAL_W] ? '1 : total_add[TOTAL_W-1:0];
                    sum_reg   <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                end
            end
            else if (((state_reg == S_FEND) && !frame_div) ||
                     ((state_reg == S_FWAIT) && div_done))
            begin
                seen_reg  <= 1'b0;
                total_reg <= '0;
                sum_reg   <= '0;
                if (state_reg == S_FWAIT)
                begin
                    last_pos_reg <= frame_pos;
                end
            end
        end
    end

    // Item, operand and result registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg  <= sensor_index;
            smp_reg  <= smp_in;
            last_reg <= frame_last;
        end
        if (state_reg == S_PREP)
        begin
            zero_reg <= (cal_max <= cal_min) || (smp_reg <= cal_min);
            sat_reg  <= ((smp_reg - cal_min) >= (cal_max - cal_min));
            num_reg  <= NUM_W'(smp_reg - cal_min) * NUM_W'(SCALE);
            rng_reg  <= cal_max - cal_min;
            wgt_reg  <= WGT_W'(idx_reg) * WGT_W'(SCALE);
        end
        if (state_reg == S_INV)
        begin
            inv_reg <= INV_W'(SCALE) - norm_val;
        end
        if (state_reg == S_FEND && !frame_div)
        begin
            position_reg  <= seen_reg ? last_pos_reg : lost_pos;
            line_seen_reg <= seen_reg;
        end
        else if (state_reg == S_FWAIT && div_done)
        begin
            position_reg  <= frame_pos;
            line_seen_reg <= 1'b1;
        end
    end

    assign position  = position_reg;
    assign line_seen = line_seen_reg;

`ifndef ASSERT_OFF
    a_meas_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req_type == REQ_MEAS) && idx_ok |=> state_reg == S_PREP)
        else $error("measurement item did not start normalization");
    a_out_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> !seen_reg && total_reg == '0 && sum_reg == '0)
        else $error("frame accumulators not cleared at frame close");
    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_NWAIT || state_reg == S_FWAIT))
        else $error("divider finished outside a wait state");
`endif

endmodule

`default_nettype wire
